[sv/appliance_panel_bridge_fsm_macros.svh]
// Assertion macros for the appliance panel bridge.
// Each macro expects aclk and aresetn to be visible in the scope where it is used.
`ifndef APPLIANCE_PANEL_BRIDGE_FSM_MACROS_SVH
`define APPLIANCE_PANEL_BRIDGE_FSM_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define APBF_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define APBF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/apbf_pkg.sv]
// Package for the appliance panel bridge: state type, command, address and button codes.
// It has no dependencies and is imported by appliance_panel_bridge_fsm.
`default_nettype none

package apbf_pkg;

    typedef enum logic [7:0] {
        ST_OFF     = 8'b0000_0001,
        ST_POWERUP = 8'b0000_0010,
        ST_IDLE    = 8'b0000_0100,
        ST_BREW    = 8'b0000_1000,
        ST_END     = 8'b0001_0000,
        ST_WATER   = 8'b0010_0000,
        ST_COVER   = 8'b0100_0000,
        ST_DRAWER  = 8'b1000_0000
    } state_t;

    typedef enum logic [1:0] {
        CMD_HOST      = 2'd0,
        CMD_BUS_WRITE = 2'd1,
        CMD_BUS_READ  = 2'd2,
        CMD_TICK      = 2'd3
    } cmd_t;

    localparam int          NUM_STATUS  = 10;
    localparam int          DELAY_W     = 20;
    localparam logic [DELAY_W-1:0] DELAY_RESET = 20'd200;

    localparam logic [7:0] ADDR_BUTTON  = 8'h00;
    localparam logic [7:0] ADDR_ALT     = 8'h80;
    localparam logic [7:0] ADDR_STATUS  = 8'h10;
    localparam logic [7:0] ADDR_STATUS_LAST = 8'h19;
    localparam logic [7:0] ADDR_POWER   = 8'h20;
    localparam logic [7:0] ALT_VALUE    = 8'h07;

    localparam logic [7:0] HB_START = 8'h73;  // 's'
    localparam logic [7:0] HB_END   = 8'h65;  // 'e'
    localparam logic [7:0] HB_E     = 8'h45;
    localparam logic [7:0] HB_M     = 8'h4D;
    localparam logic [7:0] HB_B     = 8'h42;
    localparam logic [7:0] HB_C     = 8'h43;
    localparam logic [7:0] HB_L     = 8'h4C;
    localparam logic [7:0] HB_QUERY = 8'h3F;  // '?'

    localparam logic [7:0] BTN_POWER = 8'h01;
    localparam logic [7:0] BTN_E     = 8'h02;
    localparam logic [7:0] BTN_M     = 8'h10;
    localparam logic [7:0] BTN_B     = 8'h20;
    localparam logic [7:0] BTN_C     = 8'h08;
    localparam logic [7:0] BTN_L     = 8'h04;

    localparam logic [7:0] RESET_BYTE = 8'hFF;
    localparam logic [7:0] REPLY_YES  = 8'h59;  // 'Y'
    localparam logic [7:0] REPLY_NO   = 8'h4E;  // 'N'

    localparam logic [7:0] STAT_ZERO = 8'h00;
    localparam logic [7:0] STAT_ONE  = 8'h01;
    localparam logic [7:0] STAT_TWO  = 8'h02;

    function automatic logic [7:0] state_letter(state_t s);
        logic [7:0] letter;
        unique case (s)
            ST_OFF:     letter = 8'h58;  // 'X'
            ST_POWERUP: letter = 8'h53;  // 'S'
            ST_IDLE:    letter = 8'h49;  // 'I'
            ST_BREW:    letter = 8'h42;  // 'B'
            ST_END:     letter = 8'h45;  // 'E'
            ST_WATER:   letter = 8'h57;  // 'W'
            ST_COVER:   letter = 8'h43;  // 'C'
            ST_DRAWER:  letter = 8'h44;  // 'D'
            default:    letter = 8'h58;
        endcase
        return letter;
    endfunction

endpackage

`default_nettype wire

[sv/appliance_panel_bridge_fsm.sv]
// Top level of the appliance panel bridge: event stream in, reply word out, APB register.
// Depends on apbf_pkg and appliance_panel_bridge_fsm_macros.svh.
`default_nettype none
`include "appliance_panel_bridge_fsm_macros.svh"

// The bridge takes one event word per cycle while the output is not held by m_tready, and
// returns one result word for each. An accepted word lands in an input register, is
// evaluated by one level of compare and select logic against the panel state, and its
// result is then registered in the output register. The input register doubles as a skid
// stage, so one more word is taken while a result waits on m_tready. The check delay
// register at byte address 0 should only be written while no words are in flight.
module appliance_panel_bridge_fsm
    import apbf_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    // Fields from bit 0: host_byte[7:0], reg_addr[15:8], reg_data[23:16].
    input  wire logic [23:0] s_tdata,
    // Fields from bit 0: command[1:0].
    input  wire logic [1:0]  s_tuser,

    output logic             m_tvalid,
    input  wire logic        m_tready,
    // Fields from bit 0: reply_valid[0], reply_byte[8:1], read_byte[16:9], irq[17],
    // zero padding[23:18].
    output logic [23:0]      m_tdata,

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [DELAY_W-1:0] delay_reg;

    logic               in_valid_reg, in_valid_next;
    logic [1:0]         in_cmd_reg;
    logic [7:0]         in_host_reg, in_addr_reg, in_data_reg;

    logic               m_valid_reg, m_valid_next;
    logic               out_reply_valid_reg, out_reply_valid_next;
    logic [7:0]         out_reply_byte_reg, out_reply_byte_next;
    logic [7:0]         out_read_byte_reg, out_read_byte_next;
    logic               out_irq_reg;

    state_t             state_reg, state_next;
    logic [7:0]         button_reg, button_next;
    logic [7:0]         status_reg [NUM_STATUS];
    logic [7:0]         status_next [NUM_STATUS];
    logic [7:0]         power_reg, power_next;
    logic               ptr_alt_reg, ptr_alt_next;
    logic [7:0]         saved_reg, saved_next;
    logic               irq_reg, irq_next;
    logic [DELAY_W-1:0] check_countdown_reg, check_countdown_next;
    logic               check_armed_reg, check_armed_next;

    logic               out_ready, step, s_accept;
    logic [DELAY_W-1:0] arm_value, count_dec;
    logic [3:0]         status_idx;
    logic               all_ok;
    state_t             fault_state;

    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == 1'b0) ? {{(32-DELAY_W){1'b0}}, delay_reg} : 32'd0;

    assign out_ready = !m_valid_reg || m_tready;
    assign step      = in_valid_reg && out_ready;
    assign s_tready  = !in_valid_reg || out_ready;
    assign s_accept  = s_tvalid && s_tready;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {6'd0, out_irq_reg, out_read_byte_reg, out_reply_byte_reg,
                        out_reply_valid_reg};

    assign arm_value  = (delay_reg == '0) ? DELAY_W'(1) : delay_reg;
    assign count_dec  = (check_countdown_reg != '0) ? check_countdown_reg - DELAY_W'(1)
                                                     : '0;
    assign status_idx = 4'(in_addr_reg - ADDR_STATUS);
    assign all_ok     = (status_reg[5] == STAT_ONE) && (status_reg[6] == STAT_ONE) &&
                        (status_reg[7] == STAT_ONE) && (status_reg[8] == STAT_ONE) &&
                        (status_reg[9] == STAT_ONE);

    always_comb begin
        fault_state = state_reg;
        if (status_reg[4] == STAT_TWO) fault_state = ST_WATER;
        if (status_reg[5] == STAT_TWO) fault_state = ST_COVER;
        if (status_reg[8] == STAT_TWO) fault_state = ST_DRAWER;
    end

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (step) begin
            in_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (step) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_comb begin
        state_next           = state_reg;
        button_next          = button_reg;
        status_next          = status_reg;
        power_next           = power_reg;
        ptr_alt_next         = ptr_alt_reg;
        saved_next           = saved_reg;
        irq_next             = irq_reg;
        check_countdown_next = check_countdown_reg;
        check_armed_next     = check_armed_reg;
        out_reply_valid_next = 1'b0;
        out_reply_byte_next  = 8'h00;
        out_read_byte_next   = 8'h00;
        if (step) begin
            unique case (cmd_t'(in_cmd_reg))
                CMD_HOST: begin
                    unique case (in_host_reg)
                        HB_START: begin
                            out_reply_valid_next = 1'b1;
                            if (state_reg != ST_OFF) begin
                                out_reply_byte_next = REPLY_NO;
                            end else begin
                                out_reply_byte_next = REPLY_YES;
                                button_next = BTN_POWER;
                                state_next  = ST_POWERUP;
                                irq_next    = 1'b1;
                            end
                        end
                        HB_END: begin
                            out_reply_valid_next = 1'b1;
                            if (state_reg == ST_OFF) begin
                                out_reply_byte_next = REPLY_NO;
                            end else begin
                                out_reply_byte_next = REPLY_YES;
                                button_next = BTN_POWER;
                                state_next  = ST_END;
                                irq_next    = 1'b1;
                            end
                        end
                        HB_E, HB_M, HB_B, HB_C, HB_L: begin
                            out_reply_valid_next = 1'b1;
                            if (state_reg != ST_IDLE) begin
                                out_reply_byte_next = REPLY_NO;
                            end else begin
                                out_reply_byte_next = REPLY_YES;
                                state_next = ST_BREW;
                                irq_next   = 1'b1;
                                priority if (in_host_reg == HB_E) button_next = BTN_E;
                                else if (in_host_reg == HB_M) button_next = BTN_M;
                                else if (in_host_reg == HB_B) button_next = BTN_B;
                                else if (in_host_reg == HB_C) button_next = BTN_C;
                                else button_next = BTN_L;
                            end
                        end
                        HB_QUERY: begin
                            out_reply_valid_next = 1'b1;
                            out_reply_byte_next  = state_letter(state_reg);
                        end
                        default: begin
                        end
                    endcase
                end
                CMD_BUS_WRITE: begin
                    priority if (in_addr_reg == ADDR_BUTTON || in_addr_reg == ADDR_ALT) begin
                        ptr_alt_next = (in_addr_reg == ADDR_ALT);
                    end else if (in_addr_reg >= ADDR_STATUS &&
                                 in_addr_reg <= ADDR_STATUS_LAST) begin
                        status_next[status_idx] = in_data_reg;
                    end else if (in_addr_reg == ADDR_POWER) begin
                        power_next = in_data_reg;
                    end
                    check_countdown_next = arm_value;
                    check_armed_next     = 1'b1;
                end
                CMD_BUS_READ: begin
                    irq_next = 1'b0;
                    if (ptr_alt_reg) begin
                        out_read_byte_next = ALT_VALUE;
                    end else begin
                        out_read_byte_next = button_reg;
                        if (button_reg != 8'h00) begin
                            saved_next  = button_reg;
                            button_next = 8'h00;
                        end else begin
                            button_next = saved_reg;
                            saved_next  = 8'h00;
                        end
                    end
                    check_countdown_next = arm_value;
                    check_armed_next     = 1'b1;
                end
                CMD_TICK: begin
                    if (check_armed_reg) begin
                        check_countdown_next = count_dec;
                        if (count_dec == '0) begin
                            check_armed_next = 1'b0;
                            priority if (button_reg == 8'h00 && state_reg == ST_POWERUP) begin
                                irq_next = 1'b1;
                                if (power_reg == STAT_ONE) begin
                                    status_next = '{default: RESET_BYTE};
                                    power_next  = RESET_BYTE;
                                    button_next = BTN_POWER;
                                    state_next  = ST_POWERUP;
                                end
                            end else if (button_reg == 8'h00 &&
                                         (state_reg == ST_END || state_reg == ST_BREW)) begin
                                irq_next = 1'b1;
                            end else if (power_reg == STAT_ONE) begin
                                status_next = '{default: RESET_BYTE};
                                power_next  = RESET_BYTE;
                                button_next = RESET_BYTE;
                                state_next  = ST_OFF;
                                irq_next    = 1'b0;
                            end else if (status_reg[1] == STAT_TWO) begin
                                state_next = ST_POWERUP;
                            end else if (status_reg[0] == STAT_ZERO &&
                                         status_reg[1] == STAT_ONE) begin
                                state_next = fault_state;
                            end else if (status_reg[0] == STAT_ONE &&
                                         status_reg[1] == STAT_ZERO) begin
                                state_next = all_ok ? ST_IDLE : ST_BREW;
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delay_reg           <= DELAY_RESET;
            in_valid_reg        <= 1'b0;
            m_valid_reg         <= 1'b0;
            state_reg           <= ST_OFF;
            button_reg          <= RESET_BYTE;
            status_reg          <= '{default: RESET_BYTE};
            power_reg           <= RESET_BYTE;
            ptr_alt_reg         <= 1'b0;
            saved_reg           <= 8'h00;
            irq_reg             <= 1'b0;
            check_countdown_reg <= '0;
            check_armed_reg     <= 1'b0;
        end else begin
            if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
                delay_reg <= pwdata[DELAY_W-1:0];
            end
            in_valid_reg        <= in_valid_next;
            m_valid_reg         <= m_valid_next;
            state_reg           <= state_next;
            button_reg          <= button_next;
            status_reg          <= status_next;
            power_reg           <= power_next;
            ptr_alt_reg         <= ptr_alt_next;
            saved_reg           <= saved_next;
            irq_reg             <= irq_next;
            check_countdown_reg <= check_countdown_next;
            check_armed_reg     <= check_armed_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_cmd_reg  <= s_tuser;
            in_host_reg <= s_tdata[7:0];
            in_addr_reg <= s_tdata[15:8];
            in_data_reg <= s_tdata[23:16];
        end
        if (step) begin
            out_reply_valid_reg <= out_reply_valid_next;
            out_reply_byte_reg  <= out_reply_byte_next;
            out_read_byte_reg   <= out_read_byte_next;
            out_irq_reg         <= irq_next;
        end
    end

    `APBF_ASSERT_NEXT(a_read_clears_irq, step && in_cmd_reg == CMD_BUS_READ, !out_irq_reg, "bus read result carries a raised irq")
    `APBF_ASSERT_NEXT(a_irq_matches, step, out_irq_reg == irq_reg, "result irq differs from the interrupt line")
    `APBF_ASSERT_IMPL(a_armed_nonzero, check_armed_reg, check_countdown_reg != '0, "armed check timer holds zero")
    `APBF_ASSERT_IMPL(a_no_reply_zero, m_valid_reg && !out_reply_valid_reg, out_reply_byte_reg == 8'h00, "reply byte set without reply_valid")

endmodule

`default_nettype wire

[tb/appliance_panel_bridge_fsm_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for appliance_panel_bridge_fsm: streams panel events in, checks
// every reply word against a predictor of the panel state, and writes the check delay over APB.
// Depends on apbf_pkg and the appliance_panel_bridge_fsm RTL.

module appliance_panel_bridge_fsm_tb;
    import apbf_pkg::*;

    localparam logic [2:0]  REG_CHECK_DELAY = 3'd0;
    localparam logic [19:0] DELAY_MAX       = 20'hFFFFF;
    localparam logic [7:0]  HB_UNKNOWN_D    = 8'h64;

    typedef struct {
        logic       reply_valid;
        logic [7:0] reply_byte;
        logic [7:0] read_byte;
        logic       irq;
    } panel_reply_t;

    class panel_reply_tracker;
        state_t       mstate;
        logic [7:0]   button;
        logic [7:0]   power;
        logic [7:0]   saved;
        logic [7:0]   status [NUM_STATUS];
        bit           ptr_alt;
        bit           irq_line;
        bit           armed;
        logic [19:0]  countdown;
        logic [19:0]  delay;
        panel_reply_t replies [$];
        int unsigned  errors;

        function new();
            errors = 0;
            delay = DELAY_RESET;
            clear_panel();
            ptr_alt = 0;
            saved = 8'h00;
            countdown = '0;
            armed = 0;
        endfunction

        function void clear_panel();
            irq_line = 0;
            button = RESET_BYTE;
            foreach (status[i]) status[i] = RESET_BYTE;
            power = RESET_BYTE;
            mstate = ST_OFF;
        endfunction

        function void arm();
            countdown = (delay == '0) ? 20'd1 : delay;
            armed = 1;
        endfunction

        function logic [7:0] letter_of(state_t s);
            case (s)
                ST_POWERUP: return "S";
                ST_IDLE:    return "I";
                ST_BREW:    return "B";
                ST_END:     return "E";
                ST_WATER:   return "W";
                ST_COVER:   return "C";
                ST_DRAWER:  return "D";
                default:    return "X";
            endcase
        endfunction

        function logic [7:0] take_button(logic [7:0] code, state_t nxt);
            button = code;
            mstate = nxt;
            irq_line = 1;
            return REPLY_YES;
        endfunction

        function void run_check();
            bit all_ok;
            if (button == 8'h00) begin
                if (mstate == ST_POWERUP) begin
                    if (power == STAT_ONE) begin
                        clear_panel();
                        button = BTN_POWER;
                        mstate = ST_POWERUP;
                    end
                    irq_line = 1;
                    return;
                end
                if (mstate == ST_END || mstate == ST_BREW) begin
                    irq_line = 1;
                    return;
                end
            end
            if (power == STAT_ONE) begin
                clear_panel();
            end else if (status[1] == STAT_TWO) begin
                mstate = ST_POWERUP;
            end else if (status[0] == STAT_ZERO && status[1] == STAT_ONE) begin
                if (status[4] == STAT_TWO) mstate = ST_WATER;
                if (status[5] == STAT_TWO) mstate = ST_COVER;
                if (status[8] == STAT_TWO) mstate = ST_DRAWER;
            end else if (status[0] == STAT_ONE && status[1] == STAT_ZERO) begin
                all_ok = 1;
                for (int i = 5; i <= 9; i++) all_ok = all_ok && (status[i] == STAT_ONE);
                mstate = all_ok ? ST_IDLE : ST_BREW;
            end
        endfunction

        function void note_event(cmd_t c, logic [23:0] d);
            panel_reply_t r;
            logic [7:0]   hb;
            logic [7:0]   addr;
            logic [7:0]   data;
            logic [7:0]   code;
            hb = d[7:0];
            addr = d[15:8];
            data = d[23:16];
            r.reply_valid = 0;
            r.reply_byte = 8'h00;
            r.read_byte = 8'h00;
            case (c)
                CMD_HOST: begin
                    r.reply_valid = 1;
                    case (hb)
                        HB_START: r.reply_byte = (mstate != ST_OFF) ? REPLY_NO
                                                 : take_button(BTN_POWER, ST_POWERUP);
                        HB_END:   r.reply_byte = (mstate == ST_OFF) ? REPLY_NO
                                                 : take_button(BTN_POWER, ST_END);
                        HB_E, HB_M, HB_B, HB_C, HB_L: begin
                            case (hb)
                                HB_E:    code = BTN_E;
                                HB_M:    code = BTN_M;
                                HB_B:    code = BTN_B;
                                HB_C:    code = BTN_C;
                                default: code = BTN_L;
                            endcase
                            r.reply_byte = (mstate != ST_IDLE) ? REPLY_NO
                                           : take_button(code, ST_BREW);
                        end
                        HB_QUERY: r.reply_byte = letter_of(mstate);
                        default:  r.reply_valid = 0;
                    endcase
                end
                CMD_BUS_WRITE: begin
                    if (addr == ADDR_BUTTON || addr == ADDR_ALT) begin
                        ptr_alt = (addr == ADDR_ALT);
                    end else if (addr >= ADDR_STATUS && addr <= ADDR_STATUS_LAST) begin
                        status[addr - ADDR_STATUS] = data;
                    end else if (addr == ADDR_POWER) begin
                        power = data;
                    end
                    arm();
                end
                CMD_BUS_READ: begin
                    irq_line = 0;
                    if (ptr_alt) begin
                        r.read_byte = ALT_VALUE;
                    end else begin
                        r.read_byte = button;
                        if (button != 8'h00) begin
                            saved = button;
                            button = 8'h00;
                        end else begin
                            button = saved;
                            saved = 8'h00;
                        end
                    end
                    arm();
                end
                default: begin
                    if (armed) begin
                        if (countdown != '0) countdown = countdown - 20'd1;
                        if (countdown == '0) begin
                            armed = 0;
                            run_check();
                        end
                    end
                end
            endcase
            r.irq = irq_line;
            replies.push_back(r);
        endfunction

        task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
            $display("%0t: mismatch on %s, got %0h, expected %0h", $time, what, got, want);
            errors++;
        endtask

        task check_reply(logic [23:0] w);
            panel_reply_t want;
            if (replies.size() == 0) begin
                report_mismatch("word with nothing pending", w, 0);
                return;
            end
            want = replies.pop_front();
            if (w[0] !== want.reply_valid) report_mismatch("reply_valid", w[0], want.reply_valid);
            if (w[8:1] !== want.reply_byte) report_mismatch("reply_byte", w[8:1], want.reply_byte);
            if (w[16:9] !== want.read_byte) report_mismatch("read_byte", w[16:9], want.read_byte);
            if (w[17] !== want.irq) report_mismatch("irq", w[17], want.irq);
        endtask

        function int pending();
            return replies.size();
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // Fields from bit 0: host_byte[7:0], reg_addr[15:8], reg_data[23:16].
    logic [23:0] s_tdata = '0;
    // Fields from bit 0: command[1:0].
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b1;
    // Fields from bit 0: reply_valid[0], reply_byte[8:1], read_byte[16:9], irq[17], padding.
    logic [23:0] m_tdata;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned phase_words;
    logic [19:0] phase_delay [6] = '{20'd1, DELAY_MAX, 20'd0, 20'd3, 20'd2, 20'd5};

    panel_reply_tracker tracker = new();

    appliance_panel_bridge_fsm i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) tracker.check_reply(m_tdata);
            m_tready <= ($urandom_range(0, 99) < recv_stall_pct) ? 1'b0 : 1'b1;
        end
    end

    task send_word(cmd_t c, logic [7:0] hb, logic [7:0] addr, logic [7:0] data);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= c;
        s_tdata <= {data, addr, hb};
        do @(posedge aclk); while (!s_tready);
        tracker.note_event(c, {data, addr, hb});
        phase_words++;
    endtask

    task send_host(logic [7:0] hb);
        send_word(CMD_HOST, hb, 8'($urandom), 8'($urandom));
    endtask

    task send_write(logic [7:0] addr, logic [7:0] data);
        send_word(CMD_BUS_WRITE, 8'($urandom), addr, data);
    endtask

    task send_read();
        send_word(CMD_BUS_READ, 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    task send_tick();
        send_word(CMD_TICK, 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    task wait_drained();
        s_tvalid <= 1'b0;
        while (tracker.pending() != 0) @(posedge aclk);
    endtask

    task write_delay(logic [19:0] v);
        repeat (4) @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= REG_CHECK_DELAY;
        pwdata <= {12'd0, v};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        tracker.delay = v;
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== {12'd0, v}) tracker.report_mismatch("check delay readback", prdata, v);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    function logic [7:0] pick_host_byte();
        case ($urandom_range(0, 11))
            0:       return HB_START;
            1:       return HB_END;
            2:       return HB_E;
            3:       return HB_M;
            4:       return HB_B;
            5:       return HB_C;
            6:       return HB_L;
            7, 8:    return HB_QUERY;
            9:       return HB_UNKNOWN_D;
            default: return 8'($urandom);
        endcase
    endfunction

    function logic [7:0] pick_addr();
        case ($urandom_range(0, 9))
            0:          return ADDR_BUTTON;
            1:          return ADDR_ALT;
            2:          return ADDR_POWER;
            3, 4, 5, 6: return ADDR_STATUS + 8'($urandom_range(0, NUM_STATUS - 1));
            default:    return 8'($urandom);
        endcase
    endfunction

    function logic [7:0] pick_data();
        case ($urandom_range(0, 5))
            0:       return STAT_ZERO;
            1:       return STAT_ONE;
            2:       return STAT_TWO;
            default: return 8'($urandom);
        endcase
    endfunction

    task run_sequence();
        logic [7:0]  pwr;
        logic [7:0]  v;
        int unsigned k;
        int unsigned eff;
        pwr = pick_data();
        if (pwr == STAT_ONE) pwr = RESET_BYTE;
        if ($urandom_range(0, 9) < 3) send_host(HB_START);
        case ($urandom_range(0, 5))
            0: send_write(ADDR_POWER, STAT_ONE);
            1: begin
                send_write(ADDR_POWER, pwr);
                send_write(ADDR_STATUS + 8'd1, STAT_TWO);
            end
            2: begin
                send_write(ADDR_POWER, pwr);
                send_write(ADDR_STATUS, STAT_ZERO);
                send_write(ADDR_STATUS + 8'd1, STAT_ONE);
                send_write(ADDR_STATUS + 8'd4, $urandom_range(0, 1) ? STAT_TWO : pick_data());
                send_write(ADDR_STATUS + 8'd5, $urandom_range(0, 1) ? STAT_TWO : pick_data());
                send_write(ADDR_STATUS + 8'd8, $urandom_range(0, 1) ? STAT_TWO : pick_data());
            end
            3, 4: begin
                send_write(ADDR_POWER, pwr);
                send_write(ADDR_STATUS, STAT_ONE);
                send_write(ADDR_STATUS + 8'd1, STAT_ZERO);
                k = $urandom_range(5, 9);
                for (int i = 5; i <= 9; i++) begin
                    v = STAT_ONE;
                    if ($urandom_range(0, 1) && i == k) begin
                        v = pick_data();
                        if (v == STAT_ONE) v = STAT_ZERO;
                    end
                    send_write(ADDR_STATUS + 8'(i), v);
                end
            end
            default: begin
                repeat ($urandom_range(1, 4)) begin
                    send_write(ADDR_STATUS + 8'($urandom_range(0, NUM_STATUS - 1)), pick_data());
                end
            end
        endcase
        send_write(($urandom_range(0, 9) == 0) ? ADDR_ALT : ADDR_BUTTON, 8'($urandom));
        repeat ($urandom_range(0, 2)) send_read();
        eff = (tracker.delay == '0) ? 1 : tracker.delay;
        if (eff <= 24) eff = eff + $urandom_range(0, 2);
        else eff = $urandom_range(1, 24);
        repeat (eff) send_tick();
        repeat ($urandom_range(1, 3)) send_host(pick_host_byte());
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        send_host(HB_QUERY);
        send_host(HB_END);
        send_host(HB_M);
        send_host(HB_UNKNOWN_D);
        send_host(8'h00);
        send_host(8'hFF);
        send_host(HB_START);
        send_host(HB_START);
        send_host(HB_QUERY);
        send_write(8'hFF, 8'hAA);
        send_write(ADDR_POWER, 8'hFF);
        send_write(ADDR_STATUS_LAST, 8'h00);
        send_write(ADDR_STATUS, 8'hFF);
        send_write(ADDR_ALT, 8'h00);
        send_read();
        send_write(ADDR_BUTTON, 8'h00);
        send_read();
        send_read();
        send_read();
        send_tick();
        send_host(HB_END);
        send_host(HB_L);
        send_host(HB_QUERY);

        for (int p = 0; p < 6; p++) begin
            wait_drained();
            write_delay(phase_delay[p]);
            case (p % 4)
                0: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct = 69;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 69;
                end
                default: begin
                    send_idle_pct = 18;
                    recv_stall_pct = 18;
                end
            endcase
            phase_words = 0;
            while (phase_words < 100) begin
                if ($urandom_range(0, 3) != 0) run_sequence();
                else repeat ($urandom_range(1, 4))
                    send_word(cmd_t'(2'($urandom_range(0, 3))), pick_host_byte(),
                              pick_addr(), pick_data());
            end
            wait_drained();
            while (phase_words < 205) begin
                if ($urandom_range(0, 3) != 0) run_sequence();
                else repeat ($urandom_range(1, 4))
                    send_word(cmd_t'(2'($urandom_range(0, 3))), pick_host_byte(),
                              pick_addr(), pick_data());
            end
        end

        recv_stall_pct = 0;
        wait_drained();
        repeat (10) @(posedge aclk);
        if (tracker.errors == 0) begin
            $display("** appliance_panel_bridge_fsm: PASSED **");
        end else begin
            $display("** appliance_panel_bridge_fsm: FAILED **");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("** appliance_panel_bridge_fsm: FAILED **");
        $finish;
    end

endmodule
